FILE: sv/lzwbc_pkg.sv
// ----------------------------------------------------------------------------
// lzwbc_pkg
// Shared types, sizes and constants of the LZW byte compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwbc_pkg;

  // Dictionary code width. Codes below FIRST_CODE are byte literals.
  localparam int CODE_WIDTH    = 12;
  // Number of hash buckets in the pair store, a power of two.
  localparam int TABLE_BUCKETS = 8192;
  localparam int BUCKET_BITS   = $clog2(TABLE_BUCKETS);
  localparam int BYTE_W        = 8;
  localparam int KEY_W         = CODE_WIDTH + BYTE_W;
  localparam int OUT_W         = 12;

  localparam logic [CODE_WIDTH:0]  FIRST_CODE = (CODE_WIDTH + 1)'(256);
  localparam logic [CODE_WIDTH:0]  CODE_LIMIT = (CODE_WIDTH + 1)'(1) << CODE_WIDTH;
  localparam logic [BUCKET_BITS:0] BUCKET_CNT = (BUCKET_BITS + 1)'(TABLE_BUCKETS);
  localparam logic [BUCKET_BITS-1:0] LAST_BUCKET = BUCKET_BITS'(TABLE_BUCKETS - 1);
  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

  // One dictionary entry: the pair (prefix, byte) and the code it stands for.
  typedef struct packed {
    logic                  valid;
    logic [CODE_WIDTH-1:0] prefix;
    logic [BYTE_W-1:0]     data;
    logic [CODE_WIDTH-1:0] code;
  } entry_t;

  // Access request to the pair store.
  typedef struct packed {
    logic                   we;
    logic                   re;
    logic [BUCKET_BITS-1:0] addr;
    entry_t                 wdata;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_RD,
    ST_CMP,
    ST_LAST
  } state_t;

endpackage

`default_nettype wire

FILE: sv/lzwbc_hash.sv
// ----------------------------------------------------------------------------
// lzwbc_hash
// Home bucket of a (prefix, byte) pair: xor-shift and multiplicative hash.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwbc_hash (
  input  wire logic [lzwbc_pkg::CODE_WIDTH-1:0]  prefix,
  input  wire logic [lzwbc_pkg::BYTE_W-1:0]      data,
  output logic      [lzwbc_pkg::BUCKET_BITS-1:0] bucket
);

  logic [lzwbc_pkg::KEY_W-1:0] key;
  logic [lzwbc_pkg::KEY_W-1:0] mixed;
  logic [31:0]                 prod;

  assign key   = {prefix, data};
  assign mixed = key ^ (key >> 7);
  // Only the low product bits matter, the rest is trimmed by synthesis.
  assign prod  = 32'(mixed) * lzwbc_pkg::HASH_MULT;
  assign bucket = prod[lzwbc_pkg::BUCKET_BITS+7:8];

endmodule

`default_nettype wire

FILE: sv/lzwbc_pair_mem.sv
// ----------------------------------------------------------------------------
// lzwbc_pair_mem
// Single-port pair store with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwbc_pair_mem (
  input  wire logic                clk,
  input  wire lzwbc_pkg::mem_req_t req,
  output lzwbc_pkg::entry_t        rdata_r
);

  lzwbc_pkg::entry_t mem [lzwbc_pkg::TABLE_BUCKETS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/lzw_byte_compressor_top.sv
// ----------------------------------------------------------------------------
// lzw_byte_compressor_top
// LZW compressor: bytes in, dictionary or literal codes out.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                   | Direction
//  --------+-----------------------------------------+----------
//  input   | in_valid, in_stall, in_byte_in, in_is_last | byte requests in
//  result  | out_valid, out_stall, out_code_out,        | code requests out
//          | out_end_of_run                             |
//
//  A byte that opens a match is taken in the idle state alone. Every other
//  byte passes accept, hash, store read and compare when its hash bucket
//  hits or is empty on the first probe. A miss on the last byte of a
//  message goes on to the last state for the final literal. Each further
//  probe of a collision chain repeats the store read and the compare, since
//  the single store port is read once per probe. After reset the store
//  is cleared one bucket a cycle, and no request is taken until it ends.
//  A stalled result holds the block in its compare or last state; a byte is
//  taken only while the block is idle and the result register can be loaded.
//
`default_nettype none

module lzw_byte_compressor_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_in,
  input  wire logic        in_is_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      out_code_out,
  output logic             out_end_of_run
);

  localparam int CW = lzwbc_pkg::CODE_WIDTH;
  localparam int BB = lzwbc_pkg::BUCKET_BITS;

  lzwbc_pkg::state_t state_r, state_nxt;

  // Current request and the pending match.
  logic [7:0]    byte_r, byte_nxt;
  logic          last_r, last_nxt;
  logic [CW-1:0] prefix_r, prefix_nxt;
  logic          prefix_valid_r, prefix_valid_nxt;

  // Dictionary bookkeeping.
  logic [CW:0]   nfc_r, nfc_nxt;
  logic [BB:0]   used_r, used_nxt;

  // Probe address (also the clear counter) and probe count.
  logic [BB-1:0] idx_r, idx_nxt;
  logic [BB-1:0] probe_r, probe_nxt;

  // Result register.
  logic                              out_valid_r, out_valid_nxt;
  logic [lzwbc_pkg::OUT_W-1:0]       out_code_r, out_code_nxt;
  logic                              out_end_r, out_end_nxt;

  logic [BB-1:0]       hash_bucket;
  lzwbc_pkg::mem_req_t mem_req;
  lzwbc_pkg::entry_t   ent;

  logic          accept;
  logic          out_free;
  logic          out_load;
  logic          hit;
  logic          free_slot;
  logic          give_up;
  logic          miss;
  logic          room;
  logic [BB-1:0] idx_inc;
  logic [CW-1:0] literal;

  lzwbc_hash u_hash (
    .prefix (prefix_r),
    .data   (byte_r),
    .bucket (hash_bucket)
  );

  lzwbc_pair_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rdata_r (ent)
  );

  // The result register can take a new code when it is empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == lzwbc_pkg::ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  assign hit       = ent.valid && (ent.prefix == prefix_r) && (ent.data == byte_r);
  assign free_slot = !ent.valid;
  // Every bucket was probed without a match or a hole: the store is full.
  assign give_up   = !hit && !free_slot && (probe_r == lzwbc_pkg::LAST_BUCKET);
  assign miss      = free_slot || give_up;
  assign room      = (nfc_r < lzwbc_pkg::CODE_LIMIT) && (used_r < lzwbc_pkg::BUCKET_CNT);
  assign idx_inc   = (idx_r == lzwbc_pkg::LAST_BUCKET) ? '0 : idx_r + 1'b1;
  assign literal   = {{(CW - 8){1'b0}}, byte_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lzwbc_pkg::ST_CLEAR: begin
        if (idx_r == lzwbc_pkg::LAST_BUCKET) state_nxt = lzwbc_pkg::ST_IDLE;
      end
      lzwbc_pkg::ST_IDLE: begin
        if (accept && prefix_valid_r) state_nxt = lzwbc_pkg::ST_HASH;
      end
      lzwbc_pkg::ST_HASH: state_nxt = lzwbc_pkg::ST_RD;
      lzwbc_pkg::ST_RD:   state_nxt = lzwbc_pkg::ST_CMP;
      lzwbc_pkg::ST_CMP: begin
        if (hit) begin
          if (!last_r || out_free) state_nxt = lzwbc_pkg::ST_IDLE;
        end else if (miss) begin
          if (out_free) state_nxt = last_r ? lzwbc_pkg::ST_LAST : lzwbc_pkg::ST_IDLE;
        end else begin
          state_nxt = lzwbc_pkg::ST_RD;
        end
      end
      lzwbc_pkg::ST_LAST: begin
        if (out_free) state_nxt = lzwbc_pkg::ST_IDLE;
      end
      default: state_nxt = lzwbc_pkg::ST_CLEAR;
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    byte_nxt         = byte_r;
    last_nxt         = last_r;
    prefix_nxt       = prefix_r;
    prefix_valid_nxt = prefix_valid_r;
    nfc_nxt          = nfc_r;
    used_nxt         = used_r;
    idx_nxt          = idx_r;
    probe_nxt        = probe_r;
    out_load         = 1'b0;
    out_code_nxt     = out_code_r;
    out_end_nxt      = out_end_r;
    mem_req          = '0;
    mem_req.addr     = idx_r;

    unique case (state_r)
      lzwbc_pkg::ST_CLEAR: begin
        mem_req.we = 1'b1;
        idx_nxt    = idx_inc;
      end
      lzwbc_pkg::ST_IDLE: begin
        if (accept) begin
          byte_nxt = in_byte_in;
          last_nxt = in_is_last;
          if (!prefix_valid_r) begin
            if (in_is_last) begin
              out_load     = 1'b1;
              out_code_nxt = lzwbc_pkg::OUT_W'(in_byte_in);
              out_end_nxt  = 1'b1;
              prefix_nxt   = '0;
            end else begin
              prefix_nxt       = {{(CW - 8){1'b0}}, in_byte_in};
              prefix_valid_nxt = 1'b1;
            end
          end
        end
      end
      lzwbc_pkg::ST_HASH: begin
        idx_nxt   = hash_bucket;
        probe_nxt = '0;
      end
      lzwbc_pkg::ST_RD: begin
        mem_req.re = 1'b1;
      end
      lzwbc_pkg::ST_CMP: begin
        if (hit) begin
          if (!last_r) begin
            prefix_nxt = ent.code;
          end else if (out_free) begin
            out_load         = 1'b1;
            out_code_nxt     = lzwbc_pkg::OUT_W'(ent.code);
            out_end_nxt      = 1'b1;
            prefix_nxt       = '0;
            prefix_valid_nxt = 1'b0;
          end
        end else if (miss) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_code_nxt = lzwbc_pkg::OUT_W'(prefix_r);
            out_end_nxt  = 1'b0;
            // The hole that ended the search is where the new pair goes.
            if (free_slot && room) begin
              mem_req.we           = 1'b1;
              mem_req.wdata.valid  = 1'b1;
              mem_req.wdata.prefix = prefix_r;
              mem_req.wdata.data   = byte_r;
              mem_req.wdata.code   = nfc_r[CW-1:0];
              nfc_nxt              = nfc_r + 1'b1;
              used_nxt             = used_r + 1'b1;
            end
            if (!last_r) prefix_nxt = literal;
          end
        end else begin
          idx_nxt   = idx_inc;
          probe_nxt = probe_r + 1'b1;
        end
      end
      lzwbc_pkg::ST_LAST: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_code_nxt     = lzwbc_pkg::OUT_W'(byte_r);
          out_end_nxt      = 1'b1;
          prefix_nxt       = '0;
          prefix_valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= lzwbc_pkg::ST_CLEAR;
      prefix_r       <= '0;
      prefix_valid_r <= 1'b0;
      nfc_r          <= lzwbc_pkg::FIRST_CODE;
      used_r         <= '0;
      idx_r          <= '0;
      probe_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      prefix_r       <= prefix_nxt;
      prefix_valid_r <= prefix_valid_nxt;
      nfc_r          <= nfc_nxt;
      used_r         <= used_nxt;
      idx_r          <= idx_nxt;
      probe_r        <= probe_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    out_code_r <= out_code_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_code_out   = out_code_r;
  assign out_end_of_run = out_end_r;

  // A waiting code is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(out_valid_r && out_stall))
    else $error("result register loaded while its code was still stalled");

  // Each new code fills exactly one bucket.
  a_used_tracks_codes: assert property (@(posedge clk) disable iff (!rst_n)
    (CW + 1)'(used_r) == nfc_r - lzwbc_pkg::FIRST_CODE)
    else $error("bucket count and code count disagree");

  // The store is written only by the clear pass or an insert on a miss.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == lzwbc_pkg::ST_CLEAR) ||
                   ((state_r == lzwbc_pkg::ST_CMP) && free_slot && out_free))
    else $error("unexpected pair store write");

  // Codes never pass the code space.
  a_code_limit: assert property (@(posedge clk) disable iff (!rst_n)
    nfc_r <= lzwbc_pkg::CODE_LIMIT)
    else $error("next free code beyond the code space");

  // A final literal always follows a code of the same message.
  a_last_follows_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lzwbc_pkg::ST_LAST) |-> out_valid_r && !out_end_r)
    else $error("final literal without its preceding code");

endmodule

`default_nettype wire
